FILE: rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants of the triangle row coverage rasterizer
// Holds coordinate and accumulator widths, register indexes and the
// control struct that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int unsigned MaxSide   = 64;
  localparam int unsigned CoordW    = 11;  // vertex coordinate width
  localparam int unsigned DiffW     = 13;  // edge vector and offset width
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned AccW      = 28;  // edge function width
  localparam int unsigned SideW     = 7;   // image side, 1..MaxSide
  localparam int unsigned PixW      = 6;   // pixel index, 0..MaxSide-1
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  // control for one multiply-accumulate step
  typedef struct packed {
    logic valid;  // step carries a product
    logic clr;    // start a new sum with this product
    logic sub;    // subtract the product
  } mac_op_t;

endpackage

`default_nettype wire

FILE: rtl/trc_mac.sv
// ----------------------------------------------------------------------------
// trc_mac: shared signed multiply-accumulate unit
// One registered product per cycle, accumulated or subtracted in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_mac
  import trc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mac_op_t                 op_i,
  input  wire logic signed [DiffW-1:0] a_i,
  input  wire logic signed [DiffW-1:0] b_i,
  output logic signed [AccW-1:0]       acc_o
);

  logic signed [ProdW-1:0] prod_q;
  mac_op_t                 op_q;
  logic signed [AccW-1:0]  acc_q, acc_d, prod_ext, base;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // accumulate stage
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign base     = op_q.clr ? '0 : acc_q;

  always_comb begin
    acc_d = acc_q;
    if (op_q.valid) begin
      acc_d = op_q.sub ? base - prod_ext : base + prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

FILE: rtl/triangle_row_coverage_rasterizer_top.sv
// Sequence: the triangle is loaded, its box is formed and its edge functions
//   are set up; each row of the box is then scanned pixel by pixel and pushed
//   out, held while the output stalls. The per-pixel edge test loop dominates.
// Throughput: one triangle at a time; in_stall_o is high while it is worked.
// Reset: image width and height return to 64, the sequencer idles and the
//   output register is empty.
// ----------------------------------------------------------------------------
// triangle_row_coverage_rasterizer_top: bounding box edge-function rasterizer
// Forms the clamped box, sets up exact edge functions with a shared MAC unit
// and walks the box one pixel per cycle, emitting one mask per row.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_row_coverage_rasterizer_top
  import trc_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [SideW-1:0]          cfg_data_i,
  // triangle input
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [CoordW-1:0]  v0_x_i,
  input  wire logic signed [CoordW-1:0]  v0_y_i,
  input  wire logic signed [CoordW-1:0]  v1_x_i,
  input  wire logic signed [CoordW-1:0]  v1_y_i,
  input  wire logic signed [CoordW-1:0]  v2_x_i,
  input  wire logic signed [CoordW-1:0]  v2_y_i,
  input  wire logic [31:0]               color_i,
  // row output
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [PixW-1:0]                row_o,
  output logic [MaxSide-1:0]             coverage_mask_o,
  output logic [31:0]                    fill_color_o,
  output logic                           last_row_o
);

  typedef enum logic [2:0] {
    StIdle, StBox, StSetup, StScan, StPush
  } state_e;

  state_e state_q;

  // configuration registers, saturated to 1..MaxSide
  logic [SideW-1:0] width_q, height_q, cfg_sat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_sat = cfg_data_i;
    if (cfg_data_i == '0) cfg_sat = SideW'(1);
    else if (cfg_data_i > SideW'(MaxSide)) cfg_sat = SideW'(MaxSide);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(MaxSide);
      height_q <= SideW'(MaxSide);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegImageWidth)  width_q  <= cfg_sat;
      if (cfg_index_i == RegImageHeight) height_q <= cfg_sat;
    end
  end

  // triangle registers
  logic signed [CoordW-1:0] vx_q [3];
  logic signed [CoordW-1:0] vy_q [3];
  logic [31:0]              color_q;

  // bounding box, computed from the vertex registers
  logic signed [DiffW-1:0] wlast, hlast, xlo, xhi, ylo, yhi, vxe [3], vye [3];
  logic [PixW-1:0]         xmin_q, xmax_q, ymin_q, ymax_q;

  assign wlast = DiffW'(width_q)  - DiffW'(1);
  assign hlast = DiffW'(height_q) - DiffW'(1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vxe[i] = DiffW'(vx_q[i]);
      vye[i] = DiffW'(vy_q[i]);
    end
    xlo = wlast; ylo = hlast; xhi = '0; yhi = '0;
    for (int i = 0; i < 3; i++) begin
      if (vxe[i] < xlo) xlo = vxe[i];
      if (vye[i] < ylo) ylo = vye[i];
      if (vxe[i] > xhi) xhi = vxe[i];
      if (vye[i] > yhi) yhi = vye[i];
    end
    if (xlo < 0) xlo = '0;
    if (ylo < 0) ylo = '0;
    if (xhi > wlast) xhi = wlast;
    if (yhi > hlast) yhi = hlast;
  end

  // edge vectors and start offsets
  logic signed [DiffW-1:0] ax, ay, bx, by, cx0, cy0;
  assign ax  = vxe[2] - vxe[0];
  assign ay  = vye[2] - vye[0];
  assign bx  = vxe[1] - vxe[0];
  assign by  = vye[1] - vye[0];
  assign cx0 = vxe[0] - DiffW'({1'b0, xmin_q});
  assign cy0 = vye[0] - DiffW'({1'b0, ymin_q});

  // shared MAC unit: area, then edge functions at the box corner
  logic [2:0]              step_q;
  mac_op_t                 mac_op;
  logic signed [DiffW-1:0] mac_a, mac_b;
  logic signed [AccW-1:0]  mac_acc;

  always_comb begin
    mac_op       = '0;
    mac_a        = ax;
    mac_b        = by;
    if (state_q == StSetup && step_q < 3'd6) begin
      mac_op.valid = 1'b1;
      mac_op.clr   = ~step_q[0];
      mac_op.sub   = step_q[0];
    end
    case (step_q)
      3'd0:    begin mac_a = ax;  mac_b = by;  end
      3'd1:    begin mac_a = bx;  mac_b = ay;  end
      3'd2:    begin mac_a = bx;  mac_b = cy0; end
      3'd3:    begin mac_a = cx0; mac_b = by;  end
      3'd4:    begin mac_a = cx0; mac_b = ay;  end
      3'd5:    begin mac_a = ax;  mac_b = cy0; end
      default: begin mac_a = ax;  mac_b = by;  end
    endcase
  end

  trc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  // pixel test on the running edge functions
  logic signed [AccW-1:0] area_q, wu_q, wv_q, wu_row_q, wv_row_q, wsum;
  logic signed [AccW-1:0] ax_e, ay_e, bx_e, by_e;
  logic [PixW-1:0]        x_q, y_q;
  logic [MaxSide-1:0]     mask_q;
  logic                   hit;

  assign ax_e = AccW'(ax);
  assign ay_e = AccW'(ay);
  assign bx_e = AccW'(bx);
  assign by_e = AccW'(by);
  assign wsum = wu_q + wv_q;

  always_comb begin
    if (area_q > 0) hit = (wu_q >= 0) && (wv_q >= 0) && (wsum <= area_q);
    else            hit = (wu_q <= 0) && (wv_q <= 0) && (wsum >= area_q);
    hit = hit && (area_q != '0);
  end

  assign in_stall_o = (state_q != StIdle);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      // a row is loaded in push, a stalled row holds, an accepted row clears
      out_valid_o <= (state_q == StPush) || (out_valid_o && out_stall_i);
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StBox;
        end
        StBox: begin
          step_q  <= '0;
          state_q <= StSetup;
        end
        StSetup: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) state_q <= StScan;
        end
        StScan: begin
          if (x_q == xmax_q) state_q <= StPush;
        end
        StPush: begin
          if (!out_valid_o || !out_stall_i) begin
            state_q <= (y_q == ymax_q) ? StIdle : StScan;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        vx_q[0] <= v0_x_i; vy_q[0] <= v0_y_i;
        vx_q[1] <= v1_x_i; vy_q[1] <= v1_y_i;
        vx_q[2] <= v2_x_i; vy_q[2] <= v2_y_i;
        color_q <= color_i;
      end
      StBox: begin
        xmin_q <= PixW'(xlo);
        xmax_q <= PixW'(xhi);
        ymin_q <= PixW'(ylo);
        ymax_q <= PixW'(yhi);
      end
      StSetup: begin
        if (step_q == 3'd3) area_q <= mac_acc;
        if (step_q == 3'd5) begin
          wu_row_q <= mac_acc;
          wu_q     <= mac_acc;
        end
        if (step_q == 3'd7) begin
          wv_row_q <= mac_acc;
          wv_q     <= mac_acc;
        end
        x_q    <= xmin_q;
        y_q    <= ymin_q;
        mask_q <= '0;
      end
      StScan: begin
        mask_q[x_q] <= hit;
        if (x_q != xmax_q) begin
          x_q  <= x_q + PixW'(1);
          wu_q <= wu_q + by_e;
          wv_q <= wv_q - ay_e;
        end
      end
      StPush: begin
        if (!out_valid_o || !out_stall_i) begin
          row_o           <= y_q;
          coverage_mask_o <= mask_q;
          fill_color_o    <= color_q;
          last_row_o      <= (y_q == ymax_q);
          // step to the next row
          mask_q   <= '0;
          x_q      <= xmin_q;
          y_q      <= y_q + PixW'(1);
          wu_row_q <= wu_row_q - bx_e;
          wv_row_q <= wv_row_q + ax_e;
          wu_q     <= wu_row_q - bx_e;
          wv_q     <= wv_row_q + ax_e;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/trc_checker.sv
// ----------------------------------------------------------------------------
// trc_checker: port-level checks of the rasterizer top level
// Watches handshakes and row sequencing on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_checker
  import trc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [PixW-1:0]    row_o,
  input wire logic [MaxSide-1:0] coverage_mask_o,
  input wire logic               last_row_o
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_o)
      && $stable(coverage_mask_o) && $stable(last_row_o))
    else $error("stalled output changed");

  // an accepted triangle keeps the input side busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // more rows are pending after a row that is not the last
  a_more_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_row_o |-> in_stall_o)
    else $error("block idle before last row");

  // no new triangle while a row is still being produced
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_row_o |-> in_stall_o)
    else $error("input ready with rows outstanding");

endmodule

bind triangle_row_coverage_rasterizer_top trc_checker u_trc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .row_o           (row_o),
  .coverage_mask_o (coverage_mask_o),
  .last_row_o      (last_row_o)
);

`default_nettype wire
